FILE: rtl/core/ec_pkg.sv
package ec_pkg;

  // field widths
  localparam int EpochW = 32;
  localparam int YearW  = 8;
  localparam int MonW   = 4;
  localparam int MdayW  = 5;
  localparam int DoyW   = 9;
  localparam int HourW  = 5;
  localparam int MinW   = 6;
  localparam int SecW   = 6;

  // internal widths
  localparam int DaysW  = 16;   // whole days since epoch, < 49711
  localparam int SodW   = 17;   // second of day, < 86400
  localparam int QuadW  = 6;    // four-year cycles since 1968, < 35
  localparam int RemW   = 11;   // day within a four-year cycle, < 1461
  localparam int MtW    = 11;   // minute of day, < 1440

  // pipeline shape
  localparam int SplitStages = 3;
  localparam int LaneStages  = 5;
  localparam int StageCount  = 1 + SplitStages + LaneStages;

  // time constants
  localparam logic [EpochW-1:0] EpochLimit = 32'd4102444800;
  localparam logic [16:0] SecsPerDay  = 17'd86400;
  localparam logic [15:0] DayRecip    = 16'd49710;  // floor(2^25 / 675)
  localparam logic [15:0] DaysToEpoch = 16'd731;    // 1968-01-01 to 1970-01-01
  localparam logic [10:0] DaysPerQuad = 11'd1461;
  localparam logic [5:0]  QuadRecip   = 6'd44;      // floor(2^16 / 1461)
  localparam logic [11:0] MinRecip    = 12'd2184;   // floor(2^15 / 15)
  localparam logic [5:0]  SecsPerMin  = 6'd60;
  localparam logic [5:0]  MinsPerHour = 6'd60;
  localparam int          HoursPerDay = 24;
  localparam logic [YearW-1:0] YearBase = 8'd68;    // 1968 - 1900
  localparam logic [8:0]  DaysLeapYear = 9'd366;
  localparam logic [8:0]  DaysCommonYear = 9'd365;

  // months
  localparam int MonthCount = 12;
  localparam logic [MonW-1:0]  MonFeb      = 4'd1;
  localparam logic [MonW-1:0]  MonLast     = 4'd11;
  localparam logic [DoyW-1:0]  LeapDayDoy  = 9'd59;
  localparam logic [MdayW-1:0] LeapDayMday = 5'd29;

  // first day of year of each month, common year
  function automatic logic [DoyW-1:0] month_start(input logic [MonW-1:0] m);
    logic [DoyW-1:0] s;
    unique case (m)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      4'd11:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/core/ec_if.sv
interface ec_in_if;
  import ec_pkg::*;
  logic              valid;
  logic              ready;
  logic [EpochW-1:0] epoch_seconds;
  modport source(output valid, output epoch_seconds, input ready);
  modport sink(input valid, input epoch_seconds, output ready);
endinterface

interface ec_out_if;
  import ec_pkg::*;
  logic             valid;
  logic             ready;
  logic [YearW-1:0] year_since_1900;
  logic [MonW-1:0]  month_index;
  logic [MdayW-1:0] day_of_month;
  logic [DoyW-1:0]  day_of_year;
  logic [HourW-1:0] hour_of_day;
  logic [MinW-1:0]  minute_of_hour;
  logic [SecW-1:0]  second_of_minute;
  logic             out_of_range;
  modport source(output valid, output year_since_1900, output month_index,
                 output day_of_month, output day_of_year, output hour_of_day,
                 output minute_of_hour, output second_of_minute,
                 output out_of_range, input ready);
  modport sink(input valid, input year_since_1900, input month_index,
               input day_of_month, input day_of_year, input hour_of_day,
               input minute_of_hour, input second_of_minute,
               input out_of_range, output ready);
endinterface

FILE: rtl/core/ec_split.sv
module ec_split (
  input  logic                             clk,
  input  logic [ec_pkg::SplitStages-1:0]   en,
  input  logic [ec_pkg::EpochW-1:0]        t,
  output logic [ec_pkg::DaysW-1:0]         days,
  output logic [ec_pkg::SodW-1:0]          sod,
  output logic                             oor
);
  import ec_pkg::*;

  // stage 1: t/128 times reciprocal of 675
  logic [40:0]       prod;
  logic [EpochW-1:0] t1;
  logic              oor1;
  // stage 2: day estimate (exact or one low) and its start second
  logic [DaysW-1:0]  qe;
  logic [EpochW-1:0] base;
  logic [EpochW-1:0] base_next;
  logic [EpochW-1:0] t2;
  logic              oor2;
  // stage 3: fix-up
  logic [EpochW-1:0] diff;
  logic [17:0]       rem;

  assign base_next = EpochW'(prod[40:25]) * EpochW'(SecsPerDay);
  assign diff      = t2 - base;
  assign rem       = diff[17:0];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod <= 41'(t[EpochW-1:7]) * 41'(DayRecip);
      t1   <= t;
      oor1 <= (t >= EpochLimit);
    end
    if (en[1]) begin
      qe   <= prod[40:25];
      base <= base_next;
      t2   <= t1;
      oor2 <= oor1;
    end
    if (en[2]) begin
      oor <= oor2;
      if (rem >= 18'(SecsPerDay)) begin
        days <= qe + 1'b1;
        sod  <= SodW'(rem - 18'(SecsPerDay));
      end else begin
        days <= qe;
        sod  <= rem[SodW-1:0];
      end
    end
  end

endmodule

FILE: rtl/core/ec_date.sv
module ec_date (
  input  logic                            clk,
  input  logic [ec_pkg::LaneStages-1:0]   en,
  input  logic [ec_pkg::DaysW-1:0]        days,
  output logic [ec_pkg::YearW-1:0]        year,
  output logic [ec_pkg::MonW-1:0]         mon,
  output logic [ec_pkg::MdayW-1:0]        mday,
  output logic [ec_pkg::DoyW-1:0]        doy
);
  import ec_pkg::*;

  // stage 1: days from 1968 and cycle estimate
  logic [DaysW-1:0] d_next;
  logic [21:0]      qprod;
  logic [DaysW-1:0] d1;
  logic [QuadW-1:0] qe1;
  // stage 2: start day of estimated cycle
  logic [DaysW-1:0] d2;
  logic [QuadW-1:0] qe2;
  logic [DaysW-1:0] base2;
  // stage 3: fixed cycle and day within it
  logic [DaysW-1:0] diff;
  logic [11:0]      r3;
  logic [QuadW-1:0] quad3;
  logic [RemW-1:0]  rem3;
  // stage 4: year within cycle
  logic [YearW-1:0] year4;
  logic [DoyW-1:0]  doy4;
  logic             leap4;
  logic [1:0]       yoff;
  logic [DoyW-1:0]  doy_next;
  // stage 5: month search
  logic [DoyW-1:0]  cmp;
  logic [MonW-1:0]  mon_next;
  logic [MdayW-1:0] mday_next;

  assign d_next = days + DaysToEpoch;
  assign qprod  = 22'(d_next) * 22'(QuadRecip);
  assign diff   = d2 - base2;
  assign r3     = diff[11:0];

  always_comb begin
    if (rem3 < RemW'(DaysLeapYear)) begin
      yoff     = 2'd0;
      doy_next = DoyW'(rem3);
    end else if (rem3 < RemW'(DaysLeapYear) + RemW'(DaysCommonYear)) begin
      yoff     = 2'd1;
      doy_next = DoyW'(rem3 - RemW'(DaysLeapYear));
    end else if (rem3 < RemW'(DaysLeapYear) + 11'd2 * RemW'(DaysCommonYear)) begin
      yoff     = 2'd2;
      doy_next = DoyW'(rem3 - RemW'(DaysLeapYear) - RemW'(DaysCommonYear));
    end else begin
      yoff     = 2'd3;
      doy_next = DoyW'(rem3 - RemW'(DaysLeapYear) - 11'd2 * RemW'(DaysCommonYear));
    end
  end

  // leap day gets its own answer; later days of a leap year shift back one
  always_comb begin
    cmp       = (leap4 && doy4 > LeapDayDoy) ? doy4 - 1'b1 : doy4;
    mon_next  = '0;
    for (int k = 1; k < MonthCount; k++) begin
      if (cmp >= month_start(MonW'(k))) mon_next = MonW'(k);
    end
    mday_next = MdayW'(cmp - month_start(mon_next) + 1'b1);
    if (leap4 && doy4 == LeapDayDoy) begin
      mon_next  = MonFeb;
      mday_next = LeapDayMday;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1  <= d_next;
      qe1 <= qprod[21:16];
    end
    if (en[1]) begin
      d2    <= d1;
      qe2   <= qe1;
      base2 <= DaysW'(qe1) * DaysW'(DaysPerQuad);
    end
    if (en[2]) begin
      if (r3 >= 12'(DaysPerQuad)) begin
        quad3 <= qe2 + 1'b1;
        rem3  <= RemW'(r3 - 12'(DaysPerQuad));
      end else begin
        quad3 <= qe2;
        rem3  <= r3[RemW-1:0];
      end
    end
    if (en[3]) begin
      year4 <= YearBase + {quad3, 2'b00} + YearW'(yoff);
      doy4  <= doy_next;
      leap4 <= (yoff == 2'd0);
    end
    if (en[4]) begin
      year <= year4;
      doy  <= doy4;
      mon  <= mon_next;
      mday <= mday_next;
    end
  end

endmodule

FILE: rtl/core/ec_clock.sv
module ec_clock (
  input  logic                            clk,
  input  logic [ec_pkg::LaneStages-1:0]   en,
  input  logic [ec_pkg::SodW-1:0]         sod,
  output logic [ec_pkg::HourW-1:0]        hour,
  output logic [ec_pkg::MinW-1:0]         minute,
  output logic [ec_pkg::SecW-1:0]         second
);
  import ec_pkg::*;

  // stage 1: sod/4 times reciprocal of 15
  logic [26:0]      p1;
  logic [SodW-1:0]  sod1;
  // stage 2: minute estimate and its start second
  logic [MtW-1:0]   mte2;
  logic [SodW-1:0]  base2;
  logic [SodW-1:0]  sod2;
  // stage 3: fix-up
  logic [SodW-1:0]  diff;
  logic [6:0]       r3;
  logic [MtW-1:0]   mt3;
  logic [SecW-1:0]  sec3;
  // stage 4: hour by threshold compare
  logic [HourW-1:0] hour_next;
  logic [HourW-1:0] hour4;
  logic [MtW-1:0]   mt4;
  logic [MtW-1:0]   hbase4;
  logic [SecW-1:0]  sec4;

  assign diff = sod2 - base2;
  assign r3   = diff[6:0];

  always_comb begin
    hour_next = '0;
    for (int k = 1; k < HoursPerDay; k++) begin
      if (mt3 >= MtW'(k) * MtW'(MinsPerHour)) hour_next = HourW'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1   <= 27'(sod[SodW-1:2]) * 27'(MinRecip);
      sod1 <= sod;
    end
    if (en[1]) begin
      mte2  <= p1[25:15];
      base2 <= SodW'(p1[25:15]) * SodW'(SecsPerMin);
      sod2  <= sod1;
    end
    if (en[2]) begin
      if (r3 >= 7'(SecsPerMin)) begin
        mt3  <= mte2 + 1'b1;
        sec3 <= SecW'(r3 - 7'(SecsPerMin));
      end else begin
        mt3  <= mte2;
        sec3 <= r3[SecW-1:0];
      end
    end
    if (en[3]) begin
      hour4  <= hour_next;
      hbase4 <= MtW'(hour_next) * MtW'(MinsPerHour);
      mt4    <= mt3;
      sec4   <= sec3;
    end
    if (en[4]) begin
      hour   <= hour4;
      minute <= MinW'(mt4 - hbase4);
      second <= sec4;
    end
  end

endmodule

FILE: rtl/core/epoch_seconds_to_calendar.sv
// Seconds-since-1970 to UTC calendar converter.
//
// stamp (sink): one transfer carries epoch_seconds, an unsigned count of
//   seconds since 1970-01-01 00:00:00 UTC.
// calendar (source): one transfer per input, in order, carrying year - 1900,
//   month (0 = Jan), day of month, day of year, hour, minute, second and
//   out_of_range. Inputs at or past 2100-01-01 00:00:00 give out_of_range = 1
//   with every other field zero. Leap years are every fourth year.
//
// Nine-deep pipeline: input register, three stages splitting days from the
// second of day (reciprocal multiply, back-multiply, one-step fix-up), then
// date and time-of-day lanes of five stages each, the last being the result
// register. Throughput: one item per cycle while calendar.ready stays high.
// Each stage holds its item until the next stage frees up, so a stalled
// receiver fills empty slots first; stamp.ready drops only when all nine
// stages hold items. Nothing is lost or repeated under stalls.
// Reset (rst, synchronous) empties the pipeline; no other state.
module epoch_seconds_to_calendar (
  input  logic      clk,
  input  logic      rst,
  ec_in_if.sink     stamp,
  ec_out_if.source  calendar
);
  import ec_pkg::*;

  logic [StageCount-1:0] vld;   // per-stage occupancy
  logic [StageCount-1:0] en;    // stage loads this cycle
  logic [EpochW-1:0]     t;     // input register

  logic [DaysW-1:0]      days;
  logic [SodW-1:0]       sod;
  logic                  oor_split;
  logic [LaneStages-1:0] oor_pipe;

  logic [YearW-1:0]      year;
  logic [MonW-1:0]       mon;
  logic [MdayW-1:0]      mday;
  logic [DoyW-1:0]       doy;
  logic [HourW-1:0]      hour;
  logic [MinW-1:0]       minute;
  logic [SecW-1:0]       second;

  // a stage may load when empty or when its item moves on
  always_comb begin
    en[StageCount-1] = !vld[StageCount-1] || calendar.ready;
    for (int i = StageCount - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= stamp.valid;
      for (int i = 1; i < StageCount; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) t <= stamp.epoch_seconds;
  end

  ec_split u_split (
    .clk  (clk),
    .en   (en[SplitStages:1]),
    .t    (t),
    .days (days),
    .sod  (sod),
    .oor  (oor_split)
  );

  // range flag rides alongside the lanes
  always_ff @(posedge clk) begin
    if (en[SplitStages+1]) oor_pipe[0] <= oor_split;
    for (int i = 1; i < LaneStages; i++) begin
      if (en[SplitStages+1+i]) oor_pipe[i] <= oor_pipe[i-1];
    end
  end

  ec_date u_date (
    .clk  (clk),
    .en   (en[StageCount-1:SplitStages+1]),
    .days (days),
    .year (year),
    .mon  (mon),
    .mday (mday),
    .doy  (doy)
  );

  ec_clock u_clock (
    .clk    (clk),
    .en     (en[StageCount-1:SplitStages+1]),
    .sod    (sod),
    .hour   (hour),
    .minute (minute),
    .second (second)
  );

  assign stamp.ready = en[0];

  assign calendar.valid            = vld[StageCount-1];
  assign calendar.out_of_range     = oor_pipe[LaneStages-1];
  assign calendar.year_since_1900  = oor_pipe[LaneStages-1] ? '0 : year;
  assign calendar.month_index      = oor_pipe[LaneStages-1] ? '0 : mon;
  assign calendar.day_of_month     = oor_pipe[LaneStages-1] ? '0 : mday;
  assign calendar.day_of_year      = oor_pipe[LaneStages-1] ? '0 : doy;
  assign calendar.hour_of_day      = oor_pipe[LaneStages-1] ? '0 : hour;
  assign calendar.minute_of_hour   = oor_pipe[LaneStages-1] ? '0 : minute;
  assign calendar.second_of_minute = oor_pipe[LaneStages-1] ? '0 : second;

  // in-range results carry a real date
  a_date_sane: assert property (@(posedge clk) disable iff (rst)
    calendar.valid && !calendar.out_of_range |->
      calendar.day_of_month != '0 && calendar.month_index <= MonLast)
    else $error("calendar date out of bounds");

  // in-range results carry a real time of day
  a_time_sane: assert property (@(posedge clk) disable iff (rst)
    calendar.valid && !calendar.out_of_range |->
      calendar.hour_of_day < HourW'(HoursPerDay) &&
      calendar.minute_of_hour < MinsPerHour &&
      calendar.second_of_minute < SecsPerMin)
    else $error("calendar time out of bounds");

  // taking input under a stalled output needs a free slot somewhere
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    stamp.ready && calendar.valid && !calendar.ready |-> !(&vld))
    else $error("input taken with full pipeline");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !calendar.valid)
    else $error("result valid right after reset");

endmodule

FILE: sim/calendar_checker.sv
module calendar_checker (
  input  logic clk,
  input  logic rst,
  ec_in_if     stamp,
  ec_out_if    calendar,
  output int   mismatches,
  output int   open_results
);
  import ec_pkg::*;

  typedef struct packed {
    logic [YearW-1:0] year;
    logic [MonW-1:0]  month;
    logic [MdayW-1:0] mday;
    logic [DoyW-1:0]  yday;
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [SecW-1:0]  second;
    logic             out_of_range;
  } calendar_t;

  localparam logic [EpochW-1:0] FirstBeyond = 32'd4102444800;  // 2100-01-01
  localparam int unsigned DaySeconds     = 86400;
  localparam int unsigned CycleDays      = 1461;  // one leap plus three common years
  localparam int unsigned DaysFrom1968   = 731;
  localparam int unsigned LeapYearDays   = 366;
  localparam int unsigned CommonYearDays = 365;
  localparam int unsigned Feb29Yday      = 59;
  localparam int unsigned Year1968       = 68;    // counted from 1900
  localparam int unsigned LastMonth      = 11;
  localparam int unsigned MonthFirstDay [12] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  calendar_t expected_dates [$];
  calendar_t want;
  calendar_t got;

  function automatic calendar_t calendar_of(input logic [EpochW-1:0] t);
    calendar_t   r;
    int unsigned days, sod, cyc_day, cyc, rem, yoff, yday, cmp, mon;
    r = '0;
    if (t >= FirstBeyond) begin
      r.out_of_range = 1'b1;
      return r;
    end
    days    = t / DaySeconds;
    sod     = t % DaySeconds;
    cyc_day = days + DaysFrom1968;
    cyc     = cyc_day / CycleDays;
    rem     = cyc_day % CycleDays;
    if (rem < LeapYearDays) begin
      yoff = 0;
      yday = rem;
    end else begin
      yoff = 1 + (rem - LeapYearDays) / CommonYearDays;
      yday = (rem - LeapYearDays) % CommonYearDays;
    end
    if (yoff == 0 && yday == Feb29Yday) begin
      mon    = 1;
      r.mday = MdayW'(29);
    end else begin
      // past Feb 29 in a leap year: shift back onto the common-year table
      cmp = (yoff == 0 && yday > Feb29Yday) ? yday - 1 : yday;
      mon = LastMonth;
      while (mon > 0 && cmp < MonthFirstDay[mon]) mon--;
      r.mday = MdayW'(cmp - MonthFirstDay[mon] + 1);
    end
    r.year   = YearW'(Year1968 + 4 * cyc + yoff);
    r.month  = MonW'(mon);
    r.yday   = DoyW'(yday);
    r.hour   = HourW'(sod / 3600);
    r.minute = MinW'((sod / 60) % 60);
    r.second = SecW'(sod % 60);
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  initial mismatches = 0;

  always @(posedge clk) begin
    if (rst) begin
      expected_dates.delete();
      open_results <= 0;
    end else begin
      if (calendar.valid && calendar.ready) begin
        got = '{calendar.year_since_1900, calendar.month_index, calendar.day_of_month,
                calendar.day_of_year, calendar.hour_of_day, calendar.minute_of_hour,
                calendar.second_of_minute, calendar.out_of_range};
        if (expected_dates.size() == 0) begin
          $display("%0t: unexpected calendar transfer, expected none, got %h", $time, got);
          mismatches++;
        end else begin
          want = expected_dates.pop_front();
          check_field("year_since_1900", want.year, got.year);
          check_field("month_index", want.month, got.month);
          check_field("day_of_month", want.mday, got.mday);
          check_field("day_of_year", want.yday, got.yday);
          check_field("hour_of_day", want.hour, got.hour);
          check_field("minute_of_hour", want.minute, got.minute);
          check_field("second_of_minute", want.second, got.second);
          check_field("out_of_range", want.out_of_range, got.out_of_range);
        end
      end
      if (stamp.valid && stamp.ready)
        expected_dates.push_back(calendar_of(stamp.epoch_seconds));
      open_results <= expected_dates.size();
    end
  end

endmodule

FILE: sim/testbench.sv
// Stimulus and verdict for the epoch-seconds to calendar converter.
// The checker beside the block does all prediction and comparison; this
// module only feeds stamps, throttles the calendar side and decides.
module testbench;
  import ec_pkg::*;

  localparam int CycleLimit  = 400000;  // far above the slowest legal run
  localparam int RandomItems = 700;
  localparam int HoldStart   = 300;     // stamp count that triggers the long stall
  localparam int HoldCycles  = 120;
  localparam int HoldBurst   = 60;      // back-to-back stamps offered during the stall
  localparam int PauseAt     = 500;     // random index where the sender waits for drain
  localparam int TailCycles  = 20;      // > pipeline depth, catches stray transfers
  localparam int CornerCount = 24;

  localparam logic [EpochW-1:0] BeyondFirst = 32'd4102444800;  // 2100-01-01 00:00:00
  localparam int unsigned DaySeconds  = 86400;
  localparam int unsigned InRangeDays = 47482;  // whole days 1970..2099
  localparam int unsigned Days1972    = 730;    // first leap year after the epoch
  localparam int unsigned CycleDays   = 1461;

  // Corner stamps: time-of-day edges, year and leap-day edges, the last
  // in-range second, the first out-of-range second, and bit patterns.
  localparam logic [EpochW-1:0] CornerStamps [CornerCount] = '{
    32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
    32'd31535999,   // 1970-12-31 23:59:59
    32'd31536000,   // 1971-01-01
    32'd68169600,   // 1972-02-29, leap day
    32'd68256000,   // 1972-03-01
    32'd94694399,   // 1972-12-31 23:59:59, day of year 365
    32'd946684799,  // 1999-12-31 23:59:59
    32'd951782400,  // 2000-02-29
    32'd983404800,  // 2001-03-01, common year day 59
    32'd1735689599, // 2024-12-31 23:59:59
    32'h7FFFFFFF, 32'h80000000,
    32'd4102444799, // 2099-12-31 23:59:59, last in range
    32'd4102444800, // first out of range
    32'hFFFFFFFF, 32'hAAAAAAAA, 32'h55555555
  };

  logic clk;
  logic rst;
  int   mismatches;
  int   open_results;
  int   cycles;
  int   sent;
  int   stall;
  bit   hold_done;

  ec_in_if  stamp_if ();
  ec_out_if cal_if ();

  epoch_seconds_to_calendar dut (
    .clk      (clk),
    .rst      (rst),
    .stamp    (stamp_if),
    .calendar (cal_if)
  );

  calendar_checker date_check (
    .clk          (clk),
    .rst          (rst),
    .stamp        (stamp_if),
    .calendar     (cal_if),
    .mismatches   (mismatches),
    .open_results (open_results)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // mostly no gap, some short, a few long
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ready-high run: short usually, sometimes a long stretch with no stall
  function automatic int run_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 8);
    return $urandom_range(30, 80);
  endfunction

  // Random stamp mix: full 32-bit range (hits the out-of-range flag and
  // every bit), uniform in range, day edges, leap-year hot spots, and the
  // 2100 boundary.
  function automatic logic [EpochW-1:0] random_stamp();
    longint unsigned days, offs;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom();
      3, 4, 5: return $urandom_range(0, 32'd4102444799);
      6, 7: begin
        days = $urandom_range(0, InRangeDays - 1);
        case ($urandom_range(0, 3))
          0:       offs = 0;
          1:       offs = DaySeconds - 1;
          2:       offs = 3600 * $urandom_range(0, 23) + $urandom_range(0, 1) * 3599;
          default: offs = $urandom_range(0, DaySeconds - 1);
        endcase
        return EpochW'(days * DaySeconds + offs);
      end
      8: begin
        // around Feb 28/29/Mar 1 or Dec 31 of a leap year, 1972..2096
        days = Days1972 + CycleDays * $urandom_range(0, 31);
        case ($urandom_range(0, 4))
          0:       days += 58;
          1:       days += 59;
          2:       days += 60;
          3:       days += 365;
          default: days += $urandom_range(0, 365);
        endcase
        return EpochW'(days * DaySeconds + $urandom_range(0, DaySeconds - 1));
      end
      default: return BeyondFirst - 100 + $urandom_range(0, 200);
    endcase
  endfunction

  // Offer one stamp after an optional gap and hold it until the transfer.
  // valid stays high between back-to-back stamps.
  task automatic offer(input logic [EpochW-1:0] t, input int gap);
    if (gap > 0) begin
      stamp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stamp_if.valid         <= 1'b1;
    stamp_if.epoch_seconds <= t;
    @(posedge clk);
    while (!stamp_if.ready) @(posedge clk);
    sent++;
  endtask

  // Stop sending until every predicted result has come back. The count
  // from the checker is registered, so always step at least once.
  task automatic drain();
    stamp_if.valid <= 1'b0;
    do @(posedge clk); while (open_results != 0);
  endtask

  // calendar side: random stalls, plus one long hold while stamps keep coming
  initial begin
    cal_if.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (!hold_done && sent >= HoldStart) begin
        // pipeline fills and stamp.ready must drop
        cal_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        cal_if.ready <= 1'b1;
        repeat (run_len()) @(posedge clk);
        stall = idle_len();
        if (stall > 0) begin
          cal_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // stamp side and verdict
  initial begin
    rst                    = 1'b1;
    stamp_if.valid         = 1'b0;
    stamp_if.epoch_seconds = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < CornerCount; i++)
      offer(CornerStamps[i], idle_len());
    drain();

    for (int i = 0; i < RandomItems; i++) begin
      if (i == PauseAt) drain();
      // no gaps while the calendar side is held off, so the block backs up
      if (sent >= HoldStart && sent < HoldStart + HoldBurst)
        offer(random_stamp(), 0);
      else
        offer(random_stamp(), idle_len());
    end

    drain();
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: epoch_seconds_to_calendar.f
rtl/core/ec_pkg.sv
rtl/core/ec_if.sv
rtl/core/ec_split.sv
rtl/core/ec_date.sv
rtl/core/ec_clock.sv
rtl/core/epoch_seconds_to_calendar.sv
sim/calendar_checker.sv
sim/testbench.sv
